// ===== rtl/smx_pkg.sv =====
// Shared constants, codes and command types of the stack machine execute unit.
package smx_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int CODE_DEPTH  = 1024;
  localparam int MAX_LEVEL   = 15;

  localparam int SA_W   = $clog2(STACK_DEPTH);
  localparam int TOP_W  = SA_W + 1;
  localparam int PC_W   = $clog2(CODE_DEPTH);
  localparam int ADDR_W = 34;
  localparam int LVL_W  = 4;
  localparam int NPC_W  = 10;
  localparam int DW     = 32;

  typedef enum logic [4:0] {
    OP_LA, OP_LV, OP_LC, OP_LI, OP_INT, OP_DCT, OP_J, OP_FJ, OP_HL, OP_ST,
    OP_CALL, OP_EP, OP_EF, OP_RC, OP_RI, OP_WRC, OP_WRI, OP_WLN,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_CV,
    OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE, OP_BP, OP_BAD
  } op_t;

  typedef enum logic [2:0] {K_NONE, K_INT, K_CHR, K_NL, K_BP} kind_t;

  typedef enum logic [1:0] {ST_OK, ST_BADOP, ST_DIVZ, ST_STACK} status_t;

  typedef enum logic [3:0] {
    A_T, A_TM1, A_T1, A_T2, A_T3, A_T4, A_B1, A_B2, A_CUR3, A_CURQ, A_X
  } addr_sel_t;

  typedef enum logic [3:0] {
    D_CURQ, D_X, D_Q, D_Y, D_INV, D_NEGX, D_R, D_B, D_PC, D_CUR
  } wdat_sel_t;

  typedef enum logic [2:0] {
    NT_SAME, NT_INC, NT_DEC, NT_DEC2, NT_ADDQ, NT_SUBQ, NT_BM1, NT_B
  } nt_sel_t;

  typedef enum logic [1:0] {NB_SAME, NB_T1, NB_Y} nb_sel_t;

  typedef enum logic [2:0] {P_INC, P_Q, P_FJ, P_SAME, P_X1} pc_sel_t;

  typedef struct packed {
    op_t       op;
    logic      latch;
    logic      rd_en;
    logic      wr_en;
    addr_sel_t as;
    wdat_sel_t wd;
    logic      cap_x;
    logic      cap_y;
    logic      cap_cur;
    logic      cap_r;
    logic      div_start;
    logic      chk_wr;
    nt_sel_t   nt;
    nb_sel_t   nb;
    pc_sel_t   pcs;
    logic      fin;
    kind_t     kind;
    logic      hlt;
    status_t   st;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic addr_bad;
    logic chk_bad;
    logic y_zero;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/smx_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module smx_div
  import smx_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  logic          busy;
  logic          fin;
  logic [4:0]    cnt;
  logic          neg;
  logic [DW-1:0] quo;
  logic [DW-1:0] ub;
  logic [DW:0]   rem;
  logic [DW:0]   rs;

  assign rs       = {rem[DW-1:0], quo[DW-1]};
  assign done     = fin && !busy;
  assign quotient = neg ? (DW'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      fin  <= 1'b0;
      cnt  <= '1;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1] ^ divisor[DW-1];
      quo <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
      ub  <= divisor[DW-1] ? (DW'(0) - divisor) : divisor;
      rem <= '0;
    end else if (busy) begin
      if (rs >= {1'b0, ub}) begin
        rem <= rs - {1'b0, ub};
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rs;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/smx_dpath.sv =====
// Datapath: data stack memory, machine registers, address and result logic, outputs.
module smx_dpath
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic signed [DW-1:0] operand,
  input  logic signed [DW-1:0] in_value,
  output dp_stat_t             stat,
  output logic [NPC_W-1:0]     next_pc,
  output logic [2:0]           out_kind,
  output logic signed [DW-1:0] out_value,
  output logic                 halted,
  output logic [1:0]           status
);

  localparam logic signed [ADDR_W-1:0] SD_X    = ADDR_W'(STACK_DEPTH);
  localparam logic signed [ADDR_W-1:0] NEG_ONE = '1;

  logic [DW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] mem_q;

  logic signed [TOP_W-1:0] top;
  logic [SA_W-1:0]         base;
  logic [PC_W-1:0]         pc;
  logic                    halt_f;

  logic signed [DW-1:0] q;
  logic [DW-1:0]        inval;
  logic signed [DW-1:0] cur;
  logic [DW-1:0]        x;
  logic [DW-1:0]        y;
  logic [DW-1:0]        res;

  logic signed [ADDR_W-1:0] t_x, b_x, cur_x, q_x, x_x, y_x, curq, addr, nt_v, nb_v;
  logic                     nt_bad, nb_bad;
  logic [DW-1:0]            wdata, alu_v, div_q;
  logic [PC_W-1:0]          pc_inc, npc;
  logic                     div_done;

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (x),
    .divisor  (y),
    .done     (div_done),
    .quotient (div_q)
  );

  assign t_x   = ADDR_W'(top);
  assign b_x   = {{(ADDR_W-SA_W){1'b0}}, base};
  assign cur_x = ADDR_W'(cur);
  assign q_x   = ADDR_W'(q);
  assign x_x   = ADDR_W'(signed'(x));
  assign y_x   = ADDR_W'(signed'(y));
  assign curq  = cur_x + q_x;

  always_comb begin
    unique case (cmd.as)
      A_T:     addr = t_x;
      A_TM1:   addr = t_x - ADDR_W'(1);
      A_T1:    addr = t_x + ADDR_W'(1);
      A_T2:    addr = t_x + ADDR_W'(2);
      A_T3:    addr = t_x + ADDR_W'(3);
      A_T4:    addr = t_x + ADDR_W'(4);
      A_B1:    addr = b_x + ADDR_W'(1);
      A_B2:    addr = b_x + ADDR_W'(2);
      A_CUR3:  addr = cur_x + ADDR_W'(3);
      A_CURQ:  addr = curq;
      A_X:     addr = x_x;
      default: addr = t_x;
    endcase
  end

  always_comb begin
    unique case (cmd.nt)
      NT_SAME: nt_v = t_x;
      NT_INC:  nt_v = t_x + ADDR_W'(1);
      NT_DEC:  nt_v = t_x - ADDR_W'(1);
      NT_DEC2: nt_v = t_x - ADDR_W'(2);
      NT_ADDQ: nt_v = t_x + q_x;
      NT_SUBQ: nt_v = t_x - q_x;
      NT_BM1:  nt_v = b_x - ADDR_W'(1);
      NT_B:    nt_v = b_x;
      default: nt_v = t_x;
    endcase
  end

  always_comb begin
    unique case (cmd.nb)
      NB_SAME: nb_v = b_x;
      NB_T1:   nb_v = t_x + ADDR_W'(1);
      NB_Y:    nb_v = y_x;
      default: nb_v = b_x;
    endcase
  end

  assign nt_bad = (nt_v < NEG_ONE) || (nt_v >= SD_X);
  assign nb_bad = (nb_v < 0) || (nb_v >= SD_X);

  always_comb begin
    unique case (cmd.wd)
      D_CURQ:  wdata = curq[DW-1:0];
      D_X:     wdata = x;
      D_Q:     wdata = q;
      D_Y:     wdata = y;
      D_INV:   wdata = inval;
      D_NEGX:  wdata = DW'(0) - x;
      D_R:     wdata = res;
      D_B:     wdata = DW'(base);
      D_PC:    wdata = DW'(pc);
      D_CUR:   wdata = cur;
      default: wdata = x;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_ADD:  alu_v = x + y;
      OP_SUB:  alu_v = x - y;
      OP_MUL:  alu_v = x * y;
      OP_DIV:  alu_v = div_q;
      OP_EQ:   alu_v = DW'(x == y);
      OP_NE:   alu_v = DW'(x != y);
      OP_GT:   alu_v = DW'(signed'(x) > signed'(y));
      OP_LT:   alu_v = DW'(signed'(x) < signed'(y));
      OP_GE:   alu_v = DW'(signed'(x) >= signed'(y));
      OP_LE:   alu_v = DW'(signed'(x) <= signed'(y));
      default: alu_v = x;
    endcase
  end

  assign pc_inc = pc + PC_W'(1);

  always_comb begin
    unique case (cmd.pcs)
      P_INC:   npc = pc_inc;
      P_Q:     npc = q[PC_W-1:0];
      P_FJ:    npc = (x == '0) ? q[PC_W-1:0] : pc_inc;
      P_SAME:  npc = pc;
      P_X1:    npc = x[PC_W-1:0] + PC_W'(1);
      default: npc = pc_inc;
    endcase
  end

  assign stat.halted   = halt_f;
  assign stat.addr_bad = (addr < 0) || (addr >= SD_X);
  assign stat.chk_bad  = (cmd.chk_wr && stat.addr_bad) || nt_bad || nb_bad;
  assign stat.y_zero   = (y == '0);
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) mem_q <= mem[addr[SA_W-1:0]];
    if (cmd.wr_en) mem[addr[SA_W-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      q     <= operand;
      inval <= in_value;
      cur   <= DW'(base);
    end
    if (cmd.cap_cur) cur <= mem_q;
    if (cmd.cap_x) x <= mem_q;
    if (cmd.cap_y) y <= mem_q;
    if (cmd.cap_r) res <= alu_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= '1;
      base   <= '0;
      pc     <= '0;
      halt_f <= 1'b0;
    end else if (cmd.fin && !halt_f) begin
      if (cmd.st != ST_OK) begin
        pc <= pc_inc;
      end else begin
        top    <= nt_v[TOP_W-1:0];
        base   <= nb_v[SA_W-1:0];
        pc     <= npc;
        halt_f <= cmd.hlt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (halt_f) begin
        next_pc   <= NPC_W'(pc);
        out_kind  <= K_NONE;
        out_value <= '0;
        halted    <= 1'b1;
        status    <= ST_OK;
      end else if (cmd.st != ST_OK) begin
        next_pc   <= NPC_W'(pc_inc);
        out_kind  <= K_NONE;
        out_value <= '0;
        halted    <= 1'b0;
        status    <= cmd.st;
      end else begin
        next_pc   <= NPC_W'(npc);
        out_kind  <= cmd.kind;
        out_value <= (cmd.kind == K_INT || cmd.kind == K_CHR) ? x : '0;
        halted    <= cmd.hlt;
        status    <= ST_OK;
      end
    end
  end

endmodule

// ===== rtl/smx_ctrl.sv =====
// Controller: decodes the opcode and sequences stack reads, checks, writes and the result beat.
module smx_ctrl
  import smx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  logic [4:0]       action,
  input  logic [LVL_W-1:0] level,
  output logic             res_valid,
  input  logic             res_stall,
  input  dp_stat_t         stat,
  output cmd_t             cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_WALKC, S_RD1, S_RD1C, S_RD2, S_RD2C,
    S_DIVS, S_DIV, S_CHK, S_WR, S_FIN
  } state_t;

  typedef struct packed {
    logic      walk;
    logic      rd1;
    addr_sel_t ra1;
    logic      rd2;
    addr_sel_t ra2;
    logic      div;
    logic [1:0] nwr;
    addr_sel_t wa;
    wdat_sel_t wd;
    logic      chk_wr;
    nt_sel_t   nt;
    nb_sel_t   nb;
    pc_sel_t   pcs;
    kind_t     kind;
    logic      hlt;
  } plan_t;

  function automatic plan_t decode(op_t op);
    plan_t p;
    p = '0;
    unique case (op) inside
      OP_LA: begin
        p.walk = 1'b1; p.nwr = 2'd1; p.wa = A_T1; p.wd = D_CURQ; p.nt = NT_INC;
      end
      OP_LV: begin
        p.walk = 1'b1; p.rd1 = 1'b1; p.ra1 = A_CURQ;
        p.nwr = 2'd1; p.wa = A_T1; p.wd = D_X; p.nt = NT_INC;
      end
      OP_LC: begin
        p.nwr = 2'd1; p.wa = A_T1; p.wd = D_Q; p.nt = NT_INC;
      end
      OP_LI: begin
        p.rd1 = 1'b1; p.ra1 = A_T; p.rd2 = 1'b1; p.ra2 = A_X;
        p.nwr = 2'd1; p.wa = A_T; p.wd = D_Y;
      end
      OP_INT: p.nt = NT_ADDQ;
      OP_DCT: p.nt = NT_SUBQ;
      OP_J:   p.pcs = P_Q;
      OP_FJ: begin
        p.rd1 = 1'b1; p.ra1 = A_T; p.pcs = P_FJ; p.nt = NT_DEC;
      end
      OP_HL: begin
        p.pcs = P_SAME; p.hlt = 1'b1;
      end
      OP_ST: begin
        p.rd1 = 1'b1; p.ra1 = A_TM1; p.rd2 = 1'b1; p.ra2 = A_T;
        p.nwr = 2'd1; p.wa = A_X; p.wd = D_Y; p.nt = NT_DEC2;
      end
      OP_CALL: begin
        p.walk = 1'b1; p.nwr = 2'd3; p.wa = A_T4; p.nb = NB_T1; p.pcs = P_Q;
      end
      OP_EP, OP_EF: begin
        p.rd1 = 1'b1; p.ra1 = A_B2; p.rd2 = 1'b1; p.ra2 = A_B1;
        p.nt = (op == OP_EP) ? NT_BM1 : NT_B; p.nb = NB_Y; p.pcs = P_X1;
      end
      OP_RC, OP_RI: begin
        p.rd1 = 1'b1; p.ra1 = A_T; p.nwr = 2'd1; p.wa = A_X; p.wd = D_INV;
        p.nt = NT_DEC;
      end
      OP_WRC, OP_WRI: begin
        p.rd1 = 1'b1; p.ra1 = A_T; p.nt = NT_DEC;
        p.kind = (op == OP_WRI) ? K_INT : K_CHR;
      end
      OP_WLN: p.kind = K_NL;
      OP_NEG: begin
        p.rd1 = 1'b1; p.ra1 = A_T; p.nwr = 2'd1; p.wa = A_T; p.wd = D_NEGX;
      end
      OP_CV: begin
        p.rd1 = 1'b1; p.ra1 = A_T; p.nwr = 2'd1; p.wa = A_T1; p.wd = D_X;
        p.nt = NT_INC;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
        p.rd1 = 1'b1; p.ra1 = A_TM1; p.rd2 = 1'b1; p.ra2 = A_T;
        p.div = (op == OP_DIV); p.nwr = 2'd1; p.wa = A_TM1; p.wd = D_R;
        p.nt = NT_DEC;
      end
      OP_BP:  p.kind = K_BP;
      default: p.kind = K_NONE;
    endcase
    p.chk_wr = (p.nwr != 2'd0);
    return p;
  endfunction

  state_t          state;
  status_t         st;
  op_t             op_q;
  logic [LVL_W-1:0] cnt;
  logic [1:0]      widx;
  plan_t           pl;
  plan_t           pl_in;
  logic            accept;
  logic            slot_free;
  logic [LVL_W-1:0] lvl_sat;

  assign pl        = decode(op_q);
  assign pl_in     = decode(op_t'(action));
  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && (state == S_IDLE);
  assign slot_free = !res_valid || !res_stall;
  assign lvl_sat   = (level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : level;

  always_comb begin
    cmd      = '0;
    cmd.op   = op_q;
    cmd.nt   = pl.nt;
    cmd.nb   = pl.nb;
    cmd.pcs  = pl.pcs;
    cmd.kind = pl.kind;
    cmd.hlt  = pl.hlt;
    cmd.st   = st;
    cmd.as   = pl.wa;
    cmd.wd   = pl.wd;
    unique case (state)
      S_IDLE:  cmd.latch = accept;
      S_WALK: begin
        cmd.as    = A_CUR3;
        cmd.rd_en = (cnt != '0);
      end
      S_WALKC: cmd.cap_cur = 1'b1;
      S_RD1: begin
        cmd.as    = pl.ra1;
        cmd.rd_en = 1'b1;
      end
      S_RD1C:  cmd.cap_x = 1'b1;
      S_RD2: begin
        cmd.as    = pl.ra2;
        cmd.rd_en = 1'b1;
      end
      S_RD2C:  cmd.cap_y = 1'b1;
      S_DIVS:  cmd.div_start = 1'b1;
      S_DIV:   cmd.div_start = 1'b0;
      S_CHK: begin
        cmd.chk_wr = pl.chk_wr;
        cmd.cap_r  = 1'b1;
      end
      S_WR: begin
        cmd.wr_en = 1'b1;
        if (op_q == OP_CALL) begin
          unique case (widx)
            2'd0:    begin cmd.as = A_T2; cmd.wd = D_B;   end
            2'd1:    begin cmd.as = A_T3; cmd.wd = D_PC;  end
            default: begin cmd.as = A_T4; cmd.wd = D_CUR; end
          endcase
        end
      end
      S_FIN:   cmd.fin = slot_free;
      default: cmd.fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st        <= ST_OK;
      op_q      <= OP_BAD;
      cnt       <= '0;
      widx      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= op_t'(action);
            cnt  <= pl_in.walk ? lvl_sat : '0;
            widx <= '0;
            if (stat.halted) begin
              st    <= ST_OK;
              state <= S_FIN;
            end else if (op_t'(action) == OP_BAD) begin
              st    <= ST_BADOP;
              state <= S_FIN;
            end else begin
              st    <= ST_OK;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (cnt == '0) begin
            state <= pl.rd1 ? S_RD1 : S_CHK;
          end else if (stat.addr_bad) begin
            st    <= ST_STACK;
            state <= S_FIN;
          end else begin
            state <= S_WALKC;
          end
        end
        S_WALKC: begin
          cnt   <= cnt - LVL_W'(1);
          state <= S_WALK;
        end
        S_RD1: begin
          if (stat.addr_bad) begin
            st    <= ST_STACK;
            state <= S_FIN;
          end else begin
            state <= S_RD1C;
          end
        end
        S_RD1C: state <= pl.rd2 ? S_RD2 : S_CHK;
        S_RD2: begin
          if (stat.addr_bad) begin
            st    <= ST_STACK;
            state <= S_FIN;
          end else begin
            state <= S_RD2C;
          end
        end
        S_RD2C: state <= pl.div ? S_DIVS : S_CHK;
        S_DIVS: state <= S_DIV;
        S_DIV: begin
          if (stat.div_done) state <= S_CHK;
        end
        S_CHK: begin
          if (stat.chk_bad) begin
            st    <= ST_STACK;
            state <= S_FIN;
          end else if (pl.div && stat.y_zero) begin
            st    <= ST_DIVZ;
            state <= S_FIN;
          end else if (pl.nwr != 2'd0) begin
            state <= S_WR;
          end else begin
            state <= S_FIN;
          end
        end
        S_WR: begin
          widx <= widx + 2'd1;
          if (widx == pl.nwr - 2'd1) state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit: controller, datapath and checks.
//
// The command channel (cmd_valid/cmd_stall) carries one fetched instruction per beat:
// action, level, operand and in_value. The result channel (res_valid/res_stall) returns
// one beat per instruction: next_pc, out_kind, out_value, halted and status.
// An instruction runs on a single-port data stack memory with registered read data:
// each stack read has an address step and a capture step, each static-link hop of a
// level walk is one read, CALL makes three stack writes, and DIV waits on the
// one-bit-per-cycle divider.
// One instruction is in flight at a time; cmd_stall is high from accept until its
// result is loaded into the output register. The next instruction is accepted while
// that result waits; if res_stall holds the previous beat, the unit holds in its final
// step until the output register frees up.
// Reset (rst, synchronous) sets top to -1, frame base and pc to 0, clears the halt
// flag and drops any pending result. Stack contents are undefined until written.
// After a halt every instruction returns the halted pc with halted set.
module stack_machine_execute_unit
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [4:0]           action,
  input  logic [LVL_W-1:0]     level,
  input  logic signed [DW-1:0] operand,
  input  logic signed [DW-1:0] in_value,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [NPC_W-1:0]     next_pc,
  output logic [2:0]           out_kind,
  output logic signed [DW-1:0] out_value,
  output logic                 halted,
  output logic [1:0]           status
);

  cmd_t     cmd;
  dp_stat_t stat;

  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .action    (action),
    .level     (level),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  smx_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operand   (operand),
    .in_value  (in_value),
    .stat      (stat),
    .next_pc   (next_pc),
    .out_kind  (out_kind),
    .out_value (out_value),
    .halted    (halted),
    .status    (status)
  );

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != ST_OK) |-> (out_kind == K_NONE) && !halted)
    else $error("faulted result carries output or halt");

  a_value_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && (out_kind != K_INT) && (out_kind != K_CHR) |-> (out_value == '0))
    else $error("out_value set without write output");

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !res_valid || !res_stall)
    else $error("result overwritten while held");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for stack_machine_execute_unit with directed and random programs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smx_pkg::*;

  typedef struct packed {
    logic [4:0]  action;
    logic [3:0]  level;
    logic [31:0] operand;
    logic [31:0] in_value;
  } instr_t;

  typedef struct packed {
    logic [9:0]  npc;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        halted;
    logic [1:0]  status;
  } outcome_t;

  localparam int IDLE_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  logic [4:0]           action = '0;
  logic [LVL_W-1:0]     level = '0;
  logic signed [DW-1:0] operand = '0;
  logic signed [DW-1:0] in_value = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [NPC_W-1:0]     next_pc;
  logic [2:0]           out_kind;
  logic signed [DW-1:0] out_value;
  logic                 halted;
  logic [1:0]           status;

  stack_machine_execute_unit i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .action(action), .level(level), .operand(operand), .in_value(in_value),
    .res_valid(res_valid), .res_stall(res_stall),
    .next_pc(next_pc), .out_kind(out_kind), .out_value(out_value),
    .halted(halted), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // machine state copies: 0 = program builder, 1 = result predictor
  logic [31:0] stk [2][STACK_DEPTH];
  bit          wrt [2][STACK_DEPTH];
  longint      top_i [2];
  longint      base_i [2];
  logic [9:0]  pc_r [2];
  bit          hlt [2];

  bit          sc_bad;
  bit          sc_unsafe;
  int          pw_n;
  longint      pw_idx [3];
  logic [31:0] pw_val [3];

  instr_t   instr_q [$];
  outcome_t want_q [$];
  int       n_err = 0;
  int       n_acc = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_err++;
  endtask

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [9:0] wrap_pc(input longint q);
    return q[9:0];
  endfunction

  function automatic logic [31:0] peek(input int s, input longint idx);
    if (idx < 0 || idx >= STACK_DEPTH) begin
      sc_bad = 1'b1;
      return '0;
    end
    if (!wrt[s][idx]) sc_unsafe = 1'b1;
    return stk[s][idx];
  endfunction

  function automatic void poke(input longint idx, input logic [31:0] v);
    if (idx < 0 || idx >= STACK_DEPTH) sc_bad = 1'b1;
    else if (pw_n < 3) begin
      pw_idx[pw_n] = idx;
      pw_val[pw_n] = v;
      pw_n++;
    end
  endfunction

  function automatic longint frame_of(input int s, input int lvl);
    longint c;
    c = base_i[s];
    repeat (lvl) c = sx(peek(s, c + 3));
    return c;
  endfunction

  function automatic void run_instr(input int s, input instr_t it, input bit commit,
                                    output outcome_t o);
    op_t        op;
    int         lvl;
    longint     q, t, b, nt, nb, sa, sb;
    logic [31:0] x, y, rr, oval;
    logic [9:0] npc;
    kind_t      kind;
    status_t    st;
    bit         divz, halt;
    sc_bad = 1'b0;
    sc_unsafe = 1'b0;
    pw_n = 0;
    if (hlt[s]) begin
      o = '{pc_r[s], K_NONE, 32'd0, 1'b1, ST_OK};
      return;
    end
    op = op_t'(it.action);
    lvl = (it.level > MAX_LEVEL) ? MAX_LEVEL : it.level;
    q = sx(it.operand);
    t = top_i[s];
    b = base_i[s];
    nt = t;
    nb = b;
    npc = wrap_pc(pc_r[s] + 1);
    kind = K_NONE;
    st = ST_OK;
    oval = '0;
    rr = '0;
    divz = 1'b0;
    halt = 1'b0;
    case (op)
      OP_LA: begin
        nt = t + 1;
        poke(nt, 32'(frame_of(s, lvl) + q));
      end
      OP_LV: begin
        nt = t + 1;
        poke(nt, peek(s, frame_of(s, lvl) + q));
      end
      OP_LC: begin
        nt = t + 1;
        poke(nt, it.operand);
      end
      OP_LI: poke(t, peek(s, sx(peek(s, t))));
      OP_INT: nt = t + q;
      OP_DCT: nt = t - q;
      OP_J: npc = wrap_pc(q);
      OP_FJ: begin
        if (peek(s, t) == 0) npc = wrap_pc(q);
        nt = t - 1;
      end
      OP_HL: begin
        halt = 1'b1;
        npc = pc_r[s];
      end
      OP_ST: begin
        poke(sx(peek(s, t - 1)), peek(s, t));
        nt = t - 2;
      end
      OP_CALL: begin
        poke(t + 2, 32'(b));
        poke(t + 3, 32'(pc_r[s]));
        poke(t + 4, 32'(frame_of(s, lvl)));
        nb = t + 1;
        npc = wrap_pc(q);
      end
      OP_EP, OP_EF: begin
        nt = (op == OP_EP) ? b - 1 : b;
        npc = wrap_pc(sx(peek(s, b + 2)) + 1);
        nb = sx(peek(s, b + 1));
      end
      OP_RC, OP_RI: begin
        poke(sx(peek(s, t)), it.in_value);
        nt = t - 1;
      end
      OP_WRC, OP_WRI: begin
        oval = peek(s, t);
        kind = (op == OP_WRI) ? K_INT : K_CHR;
        nt = t - 1;
      end
      OP_WLN: kind = K_NL;
      OP_NEG: poke(t, 32'd0 - peek(s, t));
      OP_CV: begin
        poke(t + 1, peek(s, t));
        nt = t + 1;
      end
      OP_BP: kind = K_BP;
      OP_BAD: st = ST_BADOP;
      default: begin
        x = peek(s, t - 1);
        y = peek(s, t);
        sa = sx(x);
        sb = sx(y);
        case (op)
          OP_ADD: rr = x + y;
          OP_SUB: rr = x - y;
          OP_MUL: rr = x * y;
          OP_DIV: begin
            if (sb == 0) divz = 1'b1;
            else rr = 32'(sa / sb);
          end
          OP_EQ: rr = 32'(sa == sb);
          OP_NE: rr = 32'(sa != sb);
          OP_GT: rr = 32'(sa > sb);
          OP_LT: rr = 32'(sa < sb);
          OP_GE: rr = 32'(sa >= sb);
          default: rr = 32'(sa <= sb);
        endcase
        poke(t - 1, rr);
        nt = t - 1;
      end
    endcase
    if (nt < -1 || nt >= STACK_DEPTH || nb < 0 || nb >= STACK_DEPTH) sc_bad = 1'b1;
    if (st == ST_OK && sc_bad) st = ST_STACK;
    else if (st == ST_OK && divz) st = ST_DIVZ;
    if (st != ST_OK) begin
      kind = K_NONE;
      halt = 1'b0;
      npc = wrap_pc(pc_r[s] + 1);
    end
    if (kind != K_INT && kind != K_CHR) oval = '0;
    o = '{npc, kind, oval, hlt[s] | halt, st};
    if (commit) begin
      if (st == ST_OK) begin
        for (int k = 0; k < pw_n; k++) begin
          stk[s][pw_idx[k]] = pw_val[k];
          wrt[s][pw_idx[k]] = 1'b1;
        end
        top_i[s] = nt;
        base_i[s] = nb;
      end
      pc_r[s] = npc;
      if (halt) hlt[s] = 1'b1;
    end
  endfunction

  // queue an instruction only if it touches no unwritten stack entry
  function automatic bit add_instr(input instr_t it);
    outcome_t o;
    run_instr(0, it, 1'b0, o);
    if (sc_unsafe) return 1'b0;
    run_instr(0, it, 1'b1, o);
    instr_q.push_back(it);
    return 1'b1;
  endfunction

  function automatic instr_t mk(input op_t op, input int lvl, input logic [31:0] q);
    return '{op, 4'(lvl), q, $urandom};
  endfunction

  function automatic instr_t make_instr();
    instr_t it;
    int     r;
    longint t;
    it = '{5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), $urandom, $urandom};
    t = top_i[0];
    r = $urandom_range(0, 99);
    if (r < 8) begin
      if (it.action == OP_HL) it.action = OP_BP;
    end else if (t > 40 && r < 30) begin
      it.action = OP_DCT;
      it.operand = $urandom_range(1, int'(t));
    end else if (r < 30) begin
      it.action = OP_LC;
      if ($urandom_range(0, 1)) it.operand = $urandom_range(0, 40);
    end else begin
      it.action = 5'($urandom_range(0, 30));
      if (it.action == OP_HL) it.action = OP_BP;
      case (op_t'(it.action))
        OP_LA, OP_LV: begin
          if ($urandom_range(0, 9) != 0) it.level = 4'($urandom_range(0, 2));
          it.operand = $urandom_range(0, 6);
        end
        OP_INT: it.operand = $urandom_range(0, 4);
        OP_DCT: it.operand = $urandom_range(0, 3);
        OP_J, OP_FJ, OP_CALL: begin
          if ($urandom_range(0, 4) != 0) it.operand = $urandom_range(0, 1023);
          if (it.action == OP_CALL && $urandom_range(0, 9) != 0)
            it.level = 4'($urandom_range(0, 2));
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // driver
  int gap_left = 0;
  bit cv_next;
  outcome_t acc_o;

  function automatic int pick_gap();
    int r;
    if ((n_acc / 150) % 3 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cv_next = cmd_valid;
      if (cmd_valid && !cmd_stall) begin
        run_instr(1, instr_q[0], 1'b1, acc_o);
        want_q.push_back(acc_o);
        void'(instr_q.pop_front());
        n_acc++;
        cv_next = 1'b0;
        gap_left = pick_gap();
      end
      if (!cv_next) begin
        if (gap_left > 0) gap_left--;
        else if (instr_q.size() > 0) begin
          action <= instr_q[0].action;
          level <= instr_q[0].level;
          operand <= instr_q[0].operand;
          in_value <= instr_q[0].in_value;
          cv_next = 1'b1;
        end
      end
      cmd_valid <= cv_next;
    end
  end

  // monitor and receiver stalls
  int hold_left = 0;
  bit held_once = 1'b0;
  bit rs_next;
  outcome_t got, exp_o;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got = '{next_pc, out_kind, out_value, halted, status};
        if (want_q.size() == 0) report("result beat with nothing expected");
        else begin
          exp_o = want_q.pop_front();
          if (got.npc !== exp_o.npc)
            report($sformatf("next_pc %0d, want %0d", got.npc, exp_o.npc));
          if (got.kind !== exp_o.kind)
            report($sformatf("out_kind %0d, want %0d", got.kind, exp_o.kind));
          if (got.value !== exp_o.value)
            report($sformatf("out_value %h, want %h", got.value, exp_o.value));
          if (got.halted !== exp_o.halted)
            report($sformatf("halted %0b, want %0b", got.halted, exp_o.halted));
          if (got.status !== exp_o.status)
            report($sformatf("status %0d, want %0d", got.status, exp_o.status));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rs_next = 1'b1;
      end else if (!held_once && n_acc >= 300) begin
        held_once = 1'b1;
        hold_left = 200;
        rs_next = 1'b1;
      end else if ((n_acc / 150) % 3 == 1) begin
        rs_next = 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_left = $urandom_range(5, 25);
        rs_next = 1'b1;
      end else begin
        rs_next = ($urandom_range(0, 99) < 25);
      end
      res_stall <= rs_next;
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** stack_machine_execute_unit: FAILED **");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      top_i[s] = -1;
      base_i[s] = 0;
      pc_r[s] = '0;
      hlt[s] = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk[s][i] = '0;
        wrt[s][i] = 1'b0;
      end
    end
    void'(add_instr(mk(OP_LC, 15, 32'h7fff_ffff)));
    void'(add_instr(mk(OP_LC, 0, 32'h8000_0000)));
    void'(add_instr(mk(OP_ADD, 0, 32'hffff_ffff)));
    void'(add_instr(mk(OP_LC, 0, 32'd0)));
    void'(add_instr(mk(OP_DIV, 0, 32'd0)));
    void'(add_instr(mk(OP_DCT, 0, 32'd1)));
    void'(add_instr(mk(OP_LC, 0, 32'h8000_0000)));
    void'(add_instr(mk(OP_LC, 0, 32'hffff_ffff)));
    void'(add_instr(mk(OP_DIV, 0, 32'd0)));
    void'(add_instr(mk(OP_NEG, 0, 32'd0)));
    void'(add_instr(mk(OP_CV, 0, 32'd0)));
    void'(add_instr(mk(OP_EQ, 0, 32'd0)));
    void'(add_instr(mk(OP_WRI, 0, 32'd0)));
    void'(add_instr(mk(OP_LC, 0, 32'd65)));
    void'(add_instr(mk(OP_WRC, 0, 32'd0)));
    void'(add_instr(mk(OP_WLN, 0, 32'd0)));
    void'(add_instr(mk(OP_BP, 0, 32'd0)));
    void'(add_instr(mk(OP_BAD, 0, 32'd0)));
    void'(add_instr(mk(OP_INT, 0, 32'd2000)));
    void'(add_instr(mk(OP_DCT, 0, 32'd5)));
    void'(add_instr(mk(OP_J, 0, 32'd1025)));
    void'(add_instr(mk(OP_LC, 0, 32'd0)));
    void'(add_instr(mk(OP_FJ, 0, 32'hffff_ffff)));
    for (int n = 0; n < 1200; n++) begin
      for (int k = 0; k < 20; k++)
        if (add_instr(make_instr())) break;
    end
    void'(add_instr(mk(OP_HL, 0, 32'd0)));
    repeat (4) void'(add_instr(mk(OP_LC, 3, $urandom)));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (instr_q.size() > 0 || want_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_err == 0) $display("** stack_machine_execute_unit: PASSED **");
    else $display("** stack_machine_execute_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/smx_pkg.sv
rtl/smx_div.sv
rtl/smx_dpath.sv
rtl/smx_ctrl.sv
rtl/stack_machine_execute_unit.sv
tb/tb.sv
